[hdl/double_ended_queue_macros.svh]
// ----------------------------------------------------------------------------
// double_ended_queue_macros: assertion helpers
// Short forms for the clocked checks used in the queue RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Checks that a consequence holds in the cycle after a trigger.
`define DEQ_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

[hdl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Command and status codes and the default sizes of the queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEQ_DEPTH     = 256;
    localparam int DEQ_WORD_BITS = 64;

    localparam int CMD_W    = 4;
    localparam int WORD_W   = 64;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int OCOUNT_W = 9;

    // Input stream: word_in, position.
    localparam int S_TDATA_W = 72;
    // Output stream: word_out, entry_count, is_empty, zero padding.
    localparam int M_TDATA_W = 80;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 4'd0,
        CMD_PUSH_FRONT = 4'd1,
        CMD_POP_BACK   = 4'd2,
        CMD_POP_FRONT  = 4'd3,
        CMD_PEEK_BACK  = 4'd4,
        CMD_PEEK_FRONT = 4'd5,
        CMD_READ_AT    = 4'd6,
        CMD_WRITE_AT   = 4'd7,
        CMD_CLEAR      = 4'd8
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Result fields that travel beside the memory read.
    typedef struct packed {
        t_status               status;
        logic [OCOUNT_W-1:0]   count;
        logic                  empty;
    } t_res;

endpackage

[hdl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue on a ring buffer
// Push, pop and peek at both ends, indexed read and write, and clear.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports          Contents (lowest bit first)
//  command   in         i_s_axis_*     tuser: cmd; tdata: word_in, position
//  result    out        o_m_axis_*     tuser: status; tdata: word_out,
//                                      entry_count, is_empty
//
// One command is accepted per cycle while o_s_axis_tready is high. Its result
// passes through the registered read of the entry memory and then the output
// register. The front pointer and count update at acceptance, so a
// following command sees them at once. Reset clears the pointer, the count
// and all valid flags; the entry memory is not cleared, since an entry is
// only read after it was written. A stall on the result side holds the
// pipeline and drops o_s_axis_tready only when both stages are occupied.
//
module double_ended_queue
#(
    parameter int DEPTH     = deq_pkg::DEQ_DEPTH,
    parameter int WORD_BITS = deq_pkg::DEQ_WORD_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command stream.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [63:0] word_in, [71:64] position
    input  logic [deq_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // [3:0] cmd
    input  logic [deq_pkg::CMD_W-1:0]      i_s_axis_tuser,
    // Result stream.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [63:0] word_out, [72:64] entry_count, [73] is_empty, [79:74] zero
    output logic [deq_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // [1:0] status
    output logic [deq_pkg::STATUS_W-1:0]   o_m_axis_tuser
);

    import deq_pkg::*;

    `include "double_ended_queue_macros.svh"

    // Pointer addresses a slot; the count must also hold DEPTH itself.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int SUM_W = CNT_W + 1;

    // Slot of an entry at a given offset from the front, wrapped once.
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    // Input field unpacking.
    t_cmd              s_cmd;
    logic [WORD_W-1:0] s_word;
    logic [POS_W-1:0]  s_pos;

    assign s_cmd  = t_cmd'(i_s_axis_tuser);
    assign s_word = i_s_axis_tdata[WORD_W-1:0];
    assign s_pos  = i_s_axis_tdata[WORD_W +: POS_W];

    // Queue state.
    logic [PTR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;

    // Stage A: command done, memory read in flight.
    logic r_a_valid;
    logic r_a_rd;
    t_res r_a_res;

    // Output register.
    logic              r_o_valid;
    t_res              r_o_res;
    logic [WORD_W-1:0] r_o_word;

    logic s_acc, a_adv;
    logic is_full, is_empty;

    // Memory port.
    logic                 ram_we, ram_re;
    logic [PTR_W-1:0]     ram_addr;
    logic [WORD_BITS-1:0] ram_q;
    t_status              n_status;
    logic                 n_rd;

    // Stage A moves on when the output register is free or being taken.
    assign a_adv           = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_a_valid || a_adv;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    // Command decode: status, next pointer and count, memory access.
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = ST_OK;
        n_rd     = 1'b0;
        ram_we   = 1'b0;
        ram_addr = r_front;
        case (s_cmd)
            CMD_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we   = 1'b1;
                    ram_addr = slot_of(r_front, r_count);
                    n_count  = r_count + 1'b1;
                end
            end
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we   = 1'b1;
                    ram_addr = (r_front == '0) ? PTR_W'(DEPTH - 1) : r_front - 1'b1;
                    n_front  = ram_addr;
                    n_count  = r_count + 1'b1;
                end
            end
            CMD_POP_BACK, CMD_PEEK_BACK: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rd     = 1'b1;
                    ram_addr = slot_of(r_front, r_count - 1'b1);
                    if (s_cmd == CMD_POP_BACK) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rd     = 1'b1;
                    ram_addr = r_front;
                    if (s_cmd == CMD_POP_FRONT) begin
                        n_front = slot_of(r_front, CNT_W'(1));
                        n_count = r_count - 1'b1;
                    end
                end
            end
            CMD_READ_AT, CMD_WRITE_AT: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else if (CMP_W'(s_pos) >= CMP_W'(r_count)) begin
                    n_status = ST_RANGE;
                end else begin
                    // The position is below the count here, so it fits.
                    ram_addr = slot_of(r_front, CNT_W'(s_pos));
                    if (s_cmd == CMD_READ_AT) begin
                        n_rd = 1'b1;
                    end else begin
                        ram_we = 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign ram_re = s_acc && n_rd;

    deq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc && ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (s_word[WORD_BITS-1:0]),
        .o_rdata (ram_q)
    );

    // Queue state and pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_count   <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (o_s_axis_tready) begin
                r_a_valid <= s_acc;
            end
            if (a_adv) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_a_rd         <= n_rd;
            r_a_res.status <= n_status;
            r_a_res.count  <= OCOUNT_W'(n_count);
            r_a_res.empty  <= (n_count == '0);
        end
        if (a_adv && r_a_valid) begin
            r_o_res  <= r_a_res;
            r_o_word <= r_a_rd ? WORD_W'(ram_q) : '0;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {6'd0, r_o_res.empty, r_o_res.count, r_o_word};
    assign o_m_axis_tuser  = r_o_res.status;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `DEQ_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(DEPTH), "count exceeds depth")

    `DEQ_ASSERT_ALWAYS(a_stall_blocks, !(r_a_valid && r_o_valid && !i_m_axis_tready) || !o_s_axis_tready, "input taken while pipeline is full and stalled")

    `DEQ_ASSERT_NEXT(a_full_push_holds, s_acc && is_full && (s_cmd == CMD_PUSH_BACK || s_cmd == CMD_PUSH_FRONT), r_count == CNT_W'(DEPTH), "push into full queue changed the count")

    `DEQ_ASSERT_NEXT(a_pop_decrements, s_acc && !is_empty && (s_cmd == CMD_POP_BACK || s_cmd == CMD_POP_FRONT), r_count + 1'b1 == $past(r_count), "pop did not lower the count by one")

endmodule

[hdl/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram: generic single-port RAM
// One read or write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
